// ----- hdl/packed_yuv_to_bgr_converter_core_assert.svh -----
// Assertion macros shared by the converter checker.
// Depends on nothing; the including file supplies clock, reset and property.
`ifndef PACKED_YUV_TO_BGR_CONVERTER_CORE_ASSERT_SVH
`define PACKED_YUV_TO_BGR_CONVERTER_CORE_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define PYB_ASSERT_ON(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pyb: assertion failed");

// Property checked on every clock edge, reset included.
`define PYB_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pyb: assertion failed during or after reset");

`endif

// ----- hdl/pyb_pkg.sv -----
// Shared types and constants of the packed YUV to BGR converter.
// No dependencies; all other design files but the assertion header use this package.
package pyb_pkg;

    localparam int FMT_W  = 2;
    localparam int BYTE_W = 8;

    typedef enum logic [FMT_W-1:0] {
        FMT_YUY2   = 2'd0,
        FMT_UYVY   = 2'd1,
        FMT_YUV444 = 2'd2,
        FMT_GRAY   = 2'd3
    } t_format;

    // One pixel to be converted.
    typedef struct packed {
        logic [BYTE_W-1:0] luma;
        logic [BYTE_W-1:0] blue_chroma;
        logic [BYTE_W-1:0] red_chroma;
        logic              gray;
        logic              last;
    } t_pix_req;

    // Request from the byte parser to the conversion pipeline.
    typedef struct packed {
        logic     valid;
        t_pix_req req;
    } t_pix_push;

    // BT.601 coefficients in signed 3.16 fixed point.
    localparam int COEF_W = 19;
    localparam logic signed [COEF_W-1:0] COEF_LUMA    = 19'sd76309;
    localparam logic signed [COEF_W-1:0] COEF_BLUE_U  = 19'sd132201;
    localparam logic signed [COEF_W-1:0] COEF_GREEN_U = 19'sd25675;
    localparam logic signed [COEF_W-1:0] COEF_GREEN_V = 19'sd53279;
    localparam logic signed [COEF_W-1:0] COEF_RED_V   = 19'sd104597;

    localparam logic signed [BYTE_W:0] LUMA_OFS   = 9'sd16;
    localparam logic signed [BYTE_W:0] CHROMA_OFS = 9'sd128;

    // Products and sums stay below 2^27 in magnitude.
    localparam int PROD_W = 28;
    localparam int FRAC_W = 16;

endpackage

// ----- hdl/pyb_stream_if.sv -----
// Handshake channels of the converter: input byte stream and output pixels.
// Depends on pyb_pkg for the field widths.
interface pyb_byte_if;
    logic                       valid;
    logic                       ready;
    logic [pyb_pkg::BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface pyb_pix_if;
    logic                       valid;
    logic                       ready;
    logic [pyb_pkg::BYTE_W-1:0] blue;
    logic [pyb_pkg::BYTE_W-1:0] green;
    logic [pyb_pkg::BYTE_W-1:0] red;
    logic                       last_of_run;

    modport source (output valid, output blue, output green, output red,
                    output last_of_run, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input last_of_run, output ready);
endinterface

// ----- hdl/pyb_parser.sv -----
// Byte stream parser: tracks the position within a pixel group, holds luma
// and chroma bytes and issues pixel requests. Depends on pyb_pkg.
module pyb_parser (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [pyb_pkg::FMT_W-1:0]  i_cfg_wr_data,
    input  logic                       i_byte_valid,
    input  logic [pyb_pkg::BYTE_W-1:0] i_byte,
    output logic                       o_byte_ready,
    output pyb_pkg::t_pix_push         o_push,
    input  logic                       i_push_ready
);
    import pyb_pkg::*;

    t_format           r_format, n_format;
    logic [1:0]        r_phase, n_phase;
    logic [BYTE_W-1:0] r_held_luma, n_held_luma;
    logic [BYTE_W-1:0] r_held_u, n_held_u;
    logic [BYTE_W-1:0] r_held_v, n_held_v;
    logic [BYTE_W-1:0] r_second_luma, n_second_luma;
    logic              r_pend_valid, n_pend_valid;
    t_pix_req          r_pend_req, n_pend_req;

    logic     emits_now;
    logic     accept;
    t_pix_req byte_req;

    always_comb begin
        unique case (r_format)
            FMT_YUY2:   emits_now = (r_phase == 2'd3);
            FMT_UYVY:   emits_now = r_phase[1];
            FMT_YUV444: emits_now = r_phase[1];
            FMT_GRAY:   emits_now = 1'b1;
            default:    emits_now = 1'b1;
        endcase
    end

    // A byte that makes a pixel waits until the second YUY2 pixel has left and the pipeline is ready.
    assign o_byte_ready = emits_now ? (i_push_ready && !r_pend_valid) : 1'b1;
    assign accept       = i_byte_valid && o_byte_ready;

    always_comb begin
        byte_req = '{luma: r_held_luma, blue_chroma: r_held_u, red_chroma: i_byte,
                     gray: 1'b0, last: 1'b1};
        unique case (r_format)
            FMT_YUY2:   byte_req.last = 1'b0;
            FMT_UYVY: begin
                if (r_phase == 2'd3) begin
                    byte_req.luma       = i_byte;
                    byte_req.red_chroma = r_held_v;
                end
            end
            FMT_YUV444: byte_req.last = 1'b1;
            FMT_GRAY: begin
                byte_req.luma = i_byte;
                byte_req.gray = 1'b1;
            end
            default:    byte_req.last = 1'b1;
        endcase
    end

    always_comb begin
        if (r_pend_valid) begin
            o_push.valid = 1'b1;
            o_push.req   = r_pend_req;
        end else begin
            o_push.valid = accept && emits_now;
            o_push.req   = byte_req;
        end
    end

    always_comb begin
        n_format      = r_format;
        n_phase       = r_phase;
        n_held_luma   = r_held_luma;
        n_held_u      = r_held_u;
        n_held_v      = r_held_v;
        n_second_luma = r_second_luma;
        n_pend_valid  = r_pend_valid;
        n_pend_req    = r_pend_req;

        if (r_pend_valid && i_push_ready) begin
            n_pend_valid = 1'b0;
        end

        if (i_cfg_wr_en) begin
            n_format = t_format'(i_cfg_wr_data);
            n_phase  = 2'd0;
        end else if (accept) begin
            unique case (r_format)
                FMT_YUY2: begin
                    n_phase = r_phase + 2'd1;
                    unique case (r_phase)
                        2'd0: n_held_luma   = i_byte;
                        2'd1: n_held_u      = i_byte;
                        2'd2: n_second_luma = i_byte;
                        2'd3: begin
                            n_held_v     = i_byte;
                            n_pend_valid = 1'b1;
                            n_pend_req   = '{luma: r_second_luma, blue_chroma: r_held_u,
                                             red_chroma: i_byte, gray: 1'b0, last: 1'b1};
                        end
                        default: n_held_v = i_byte;
                    endcase
                end
                FMT_UYVY: begin
                    n_phase = r_phase + 2'd1;
                    unique case (r_phase)
                        2'd0:    n_held_u    = i_byte;
                        2'd1:    n_held_luma = i_byte;
                        2'd2:    n_held_v    = i_byte;
                        default: n_held_v    = r_held_v;
                    endcase
                end
                FMT_YUV444: begin
                    unique case (r_phase)
                        2'd0: begin
                            n_held_luma = i_byte;
                            n_phase     = 2'd1;
                        end
                        2'd1: begin
                            n_held_u = i_byte;
                            n_phase  = 2'd2;
                        end
                        default: begin
                            n_held_v = i_byte;
                            n_phase  = 2'd0;
                        end
                    endcase
                end
                default: n_phase = 2'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format      <= FMT_YUY2;
            r_phase       <= 2'd0;
            r_held_luma   <= '0;
            r_held_u      <= '0;
            r_held_v      <= '0;
            r_second_luma <= '0;
            r_pend_valid  <= 1'b0;
        end else begin
            r_format      <= n_format;
            r_phase       <= n_phase;
            r_held_luma   <= n_held_luma;
            r_held_u      <= n_held_u;
            r_held_v      <= n_held_v;
            r_second_luma <= n_second_luma;
            r_pend_valid  <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_req <= n_pend_req;
    end

endmodule

// ----- hdl/pyb_convert.sv -----
// Conversion pipeline: request register, product register, result register.
// Depends on pyb_pkg.
module pyb_convert (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pyb_pkg::t_pix_push         i_push,
    output logic                       o_push_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [pyb_pkg::BYTE_W-1:0] o_blue,
    output logic [pyb_pkg::BYTE_W-1:0] o_green,
    output logic [pyb_pkg::BYTE_W-1:0] o_red,
    output logic                       o_last
);
    import pyb_pkg::*;

    typedef struct packed {
        logic signed [PROD_W-1:0] luma_term;
        logic signed [PROD_W-1:0] blue_u;
        logic signed [PROD_W-1:0] green_u;
        logic signed [PROD_W-1:0] green_v;
        logic signed [PROD_W-1:0] red_v;
        logic [BYTE_W-1:0]        luma;
        logic                     gray;
        logic                     last;
    } t_prod;

    // Floor shift by the fraction width, then clamp to 0..255.
    function automatic logic [BYTE_W-1:0] clamp_u8(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-FRAC_W-1:0] q;
        q = v[PROD_W-1:FRAC_W];
        if (q[PROD_W-FRAC_W-1]) begin
            clamp_u8 = '0;
        end else if (q[PROD_W-FRAC_W-2:BYTE_W] != '0) begin
            clamp_u8 = '1;
        end else begin
            clamp_u8 = q[BYTE_W-1:0];
        end
    endfunction

    logic              r_s1_valid;
    t_pix_req          r_s1_req;
    logic              r_s2_valid;
    t_prod             r_s2, n_s2;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_blue, r_green, r_red, n_blue, n_green, n_red;
    logic              r_last;

    logic s1_free, s2_free, out_free;
    logic signed [BYTE_W:0] dy, du, dv;
    logic signed [PROD_W-1:0] sum_b, sum_g, sum_r;

    assign out_free     = !r_out_valid || i_ready;
    assign s2_free      = !r_s2_valid || out_free;
    assign s1_free      = !r_s1_valid || s2_free;
    assign o_push_ready = s1_free;

    assign dy = $signed({1'b0, r_s1_req.luma}) - LUMA_OFS;
    assign du = $signed({1'b0, r_s1_req.blue_chroma}) - CHROMA_OFS;
    assign dv = $signed({1'b0, r_s1_req.red_chroma}) - CHROMA_OFS;

    always_comb begin
        n_s2.luma_term = PROD_W'(dy) * PROD_W'(COEF_LUMA);
        n_s2.blue_u    = PROD_W'(du) * PROD_W'(COEF_BLUE_U);
        n_s2.green_u   = PROD_W'(du) * PROD_W'(COEF_GREEN_U);
        n_s2.green_v   = PROD_W'(dv) * PROD_W'(COEF_GREEN_V);
        n_s2.red_v     = PROD_W'(dv) * PROD_W'(COEF_RED_V);
        n_s2.luma      = r_s1_req.luma;
        n_s2.gray      = r_s1_req.gray;
        n_s2.last      = r_s1_req.last;
    end

    assign sum_b = r_s2.luma_term + r_s2.blue_u;
    assign sum_g = r_s2.luma_term - r_s2.green_u - r_s2.green_v;
    assign sum_r = r_s2.luma_term + r_s2.red_v;

    always_comb begin
        if (r_s2.gray) begin
            n_blue  = r_s2.luma;
            n_green = r_s2.luma;
            n_red   = r_s2.luma;
        end else begin
            n_blue  = clamp_u8(sum_b);
            n_green = clamp_u8(sum_g);
            n_red   = clamp_u8(sum_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_push.valid;
            end
            if (s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free && i_push.valid) begin
            r_s1_req <= i_push.req;
        end
        if (s2_free && r_s1_valid) begin
            r_s2 <= n_s2;
        end
        if (out_free && r_s2_valid) begin
            r_blue  <= n_blue;
            r_green <= n_green;
            r_red   <= n_red;
            r_last  <= r_s2.last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_blue  = r_blue;
    assign o_green = r_green;
    assign o_red   = r_red;
    assign o_last  = r_last;

endmodule

// ----- hdl/packed_yuv_to_bgr_converter_core.sv -----
// Packed YUV/gray byte stream to BGR pixel converter, top level.
// Throughput: one byte per cycle while the output is not stalled; a YUY2 group of four
// bytes yields two pixels. A pixel passes the request, product and result registers
// after its closing byte is accepted; the second YUY2 pixel is held in the parser and follows the first.
// Reset (synchronous, active low) empties the pipeline, selects YUY2 and
// starts a new pixel group.
module packed_yuv_to_bgr_converter_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [pyb_pkg::FMT_W-1:0] i_cfg_wr_data,
    pyb_byte_if.sink                  i_byte,
    pyb_pix_if.source                 o_pix
);
    import pyb_pkg::*;

    t_pix_push push;
    logic      push_ready;

    pyb_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte_valid  (i_byte.valid),
        .i_byte        (i_byte.stream_byte),
        .o_byte_ready  (i_byte.ready),
        .o_push        (push),
        .i_push_ready  (push_ready)
    );

    pyb_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_push_ready (push_ready),
        .o_valid      (o_pix.valid),
        .i_ready      (o_pix.ready),
        .o_blue       (o_pix.blue),
        .o_green      (o_pix.green),
        .o_red        (o_pix.red),
        .o_last       (o_pix.last_of_run)
    );

endmodule

// ----- hdl/pyb_checker.sv -----
// Port-level checks on the converter output channel, bound to the top level.
// Depends on pyb_pkg and the assertion macro header.
`include "packed_yuv_to_bgr_converter_core_assert.svh"

module pyb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [pyb_pkg::BYTE_W-1:0] i_blue,
    input logic [pyb_pkg::BYTE_W-1:0] i_green,
    input logic [pyb_pkg::BYTE_W-1:0] i_red,
    input logic                       i_last
);
    import pyb_pkg::*;

    logic                    out_stall;
    logic                    out_take;
    logic [3*BYTE_W:0]       out_pix;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_take  = i_out_valid && i_out_ready;
    assign out_pix   = {i_blue, i_green, i_red, i_last};

    // A stalled pixel keeps its value.
    `PYB_ASSERT_ON(a_out_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(out_pix))

    // The first pixel of a YUY2 pair is always followed at once by the closing one.
    `PYB_ASSERT_ON(a_pair_follows, i_clk, i_rst_n, out_take && !i_last |=> i_out_valid && i_last)

    // Reset leaves no pixel valid at the output.
    `PYB_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind packed_yuv_to_bgr_converter_core pyb_checker u_pyb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_blue      (o_pix.blue),
    .i_green     (o_pix.green),
    .i_red       (o_pix.red),
    .i_last      (o_pix.last_of_run)
);
